// ===== src/lag1d_pkg.sv =====
// ----------------------------------------------------------------------------
// Lagrange 1D basis package
// Widths, codes and the coefficient table shared by the basis evaluator.
// ----------------------------------------------------------------------------
package lag1d_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = FRAC_BITS + 1;
  localparam int OUT_W      = FRAC_BITS + 5;
  localparam int COEF_W     = 8;
  localparam int H1_W       = COEF_W + COORD_W + 1;
  localparam int H2_W       = H1_W + COORD_W + 1;
  localparam int H3_W       = H2_W + COORD_W + 1;
  localparam int Q_W        = H3_W - 2 * FRAC_BITS - 1;
  localparam int NUM_SLOTS  = 4;
  localparam int NUM_POW    = 4;
  localparam int NUM_STAGES = 5;
  localparam int ORDER_W    = 3;
  localparam int CNT_W      = 3;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int IN_DATA_W  = ((COORD_W + 7) / 8) * 8;
  localparam int OUT_BITS   = NUM_SLOTS * OUT_W + CNT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [ORDER_W-1:0] ORDER_MIN   = ORDER_W'(1);
  localparam logic [ORDER_W-1:0] ORDER_MAX   = ORDER_W'(3);
  localparam logic [ORDER_W-1:0] ORDER_RESET = ORDER_W'(1);

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_ORDER = 1'b1;

  localparam logic MODE_VALUE = 1'b0;
  localparam logic MODE_DERIV = 1'b1;

  // Word index of the order register.
  localparam logic REG_BASIS_ORDER = 1'b0;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t coef_quad_t [NUM_POW];

  typedef struct packed {
    logic e;
    logic d;
    logic c;
    logic b;
    logic a;
  } stage_ld_t;

  // Doubled polynomial coefficients of s^0..s^3, by mode, order - 1 and slot.
  localparam coef_t COEF2 [2][3][NUM_SLOTS][NUM_POW] = '{
    '{
      '{ '{2, -2, 0, 0}, '{0, 2, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0} },
      '{ '{2, -6, 4, 0}, '{0, 8, -8, 0}, '{0, -2, 4, 0}, '{0, 0, 0, 0} },
      '{ '{2, -11, 18, -9}, '{0, 18, -45, 27}, '{0, -9, 36, -27}, '{0, 2, -9, 9} }
    },
    '{
      '{ '{-2, 0, 0, 0}, '{2, 0, 0, 0}, '{0, 0, 0, 0}, '{0, 0, 0, 0} },
      '{ '{-6, 8, 0, 0}, '{8, -16, 0, 0}, '{-2, 8, 0, 0}, '{0, 0, 0, 0} },
      '{ '{-11, 36, -27, 0}, '{18, -90, 81, 0}, '{-9, 72, -81, 0}, '{2, -18, 27, 0} }
    }
  };

  function automatic logic order_ok(input logic [ORDER_W-1:0] order);
    return (order >= ORDER_MIN) && (order <= ORDER_MAX);
  endfunction

  // An unsupported order yields all-zero coefficients, so every result is zero.
  function automatic coef_quad_t coef_lookup(input logic mode,
                                             input logic [ORDER_W-1:0] order,
                                             input logic [1:0] slot);
    coef_quad_t r;
    logic [1:0] oi;
    oi = 2'(order - ORDER_MIN);
    r  = '{default: '0};
    if (order_ok(order)) begin
      r = COEF2[mode][oi][slot];
    end
    return r;
  endfunction

endpackage

// ===== src/lagrange_1d_basis_eval.sv =====
// ----------------------------------------------------------------------------
// Lagrange 1D basis evaluator
//
// Channel    Direction  Handshake            Payload
// s_axis     in         tvalid/tready        tdata: coord; tuser: mode
// m_axis     out        tvalid/tready        tdata: basis_0..3, count_valid;
//                                            tuser: status
// apb        in         psel/penable/pready  basis_order register
//
// Five register stages: coefficient fetch, three Horner multiply-add steps,
// and rounding with saturation into the output register.
// One request per cycle is taken unless the pipeline is full and the output stalled.
// Reset clears the stage valid bits and sets the order to one.
// Each stage holds when the stage after it is full and stalled, so bubbles
// are squeezed out and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module lagrange_1d_basis_eval (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [16:0] coord
  input  logic [lag1d_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // [0] mode
  input  logic [0:0]                           s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // [20:0] basis_0, [41:21] basis_1, [62:42] basis_2, [83:63] basis_3,
  // [86:84] count_valid
  output logic [lag1d_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // [0] status
  output logic [0:0]                           m_axis_tuser_o,
  input  logic                                 psel_i,
  input  logic                                 penable_i,
  input  logic                                 pwrite_i,
  input  logic [lag1d_pkg::APB_ADDR_W-1:0]     paddr_i,
  input  logic [lag1d_pkg::APB_DATA_W-1:0]     pwdata_i,
  output logic [lag1d_pkg::APB_DATA_W-1:0]     prdata_o,
  output logic                                 pready_o
);

  localparam int NS = lag1d_pkg::NUM_STAGES;

  logic [lag1d_pkg::ORDER_W-1:0] order_q, order_d;
  logic                          wr_en;

  logic [NS-1:0] vld_q, vld_d, vin, rdy, ld;
  lag1d_pkg::stage_ld_t ld_s;

  logic [lag1d_pkg::COORD_W-1:0] coord_q [3];
  logic [lag1d_pkg::CNT_W-1:0]   cnt_q [NS];
  logic                          st_q [NS];
  logic [lag1d_pkg::CNT_W-1:0]   cnt_in;
  logic                          st_in;

  logic signed [lag1d_pkg::OUT_W-1:0] res [lag1d_pkg::NUM_SLOTS];

  // Configuration port.
  assign pready_o = 1'b1;
  assign wr_en    = psel_i && penable_i && pwrite_i && pready_o
                    && (paddr_i[2] == lag1d_pkg::REG_BASIS_ORDER);
  assign order_d  = wr_en ? pwdata_i[lag1d_pkg::ORDER_W-1:0] : order_q;
  assign prdata_o = (paddr_i[2] == lag1d_pkg::REG_BASIS_ORDER)
                    ? lag1d_pkg::APB_DATA_W'(order_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= lag1d_pkg::ORDER_RESET;
    end else begin
      order_q <= order_d;
    end
  end

  // Stage valid and ready chain.
  always_comb begin
    vin = {vld_q[NS-2:0], s_axis_tvalid_i};
    rdy[NS-1] = !vld_q[NS-1] || m_axis_tready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    ld    = rdy & vin;
    vld_d = (rdy & vin) | (~rdy & vld_q);
  end

  assign ld_s = lag1d_pkg::stage_ld_t'(ld);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Side fields and the coordinate travel alongside the slot datapaths.
  assign st_in  = lag1d_pkg::order_ok(order_q) ? lag1d_pkg::STATUS_OK
                                               : lag1d_pkg::STATUS_BAD_ORDER;
  assign cnt_in = lag1d_pkg::order_ok(order_q)
                  ? lag1d_pkg::CNT_W'(order_q) + lag1d_pkg::CNT_W'(1) : '0;

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      coord_q[0] <= s_axis_tdata_i[lag1d_pkg::COORD_W-1:0];
      cnt_q[0]   <= cnt_in;
      st_q[0]    <= st_in;
    end
    for (int k = 1; k < NS; k++) begin
      if (ld[k]) begin
        cnt_q[k] <= cnt_q[k-1];
        st_q[k]  <= st_q[k-1];
      end
    end
    for (int k = 1; k < 3; k++) begin
      if (ld[k]) begin
        coord_q[k] <= coord_q[k-1];
      end
    end
  end

  for (genvar g = 0; g < lag1d_pkg::NUM_SLOTS; g++) begin : g_slot
    lag1d_pkg::coef_quad_t coef;
    assign coef = lag1d_pkg::coef_lookup(s_axis_tuser_i[0], order_q, 2'(g));

    lag1d_slot u_slot (
      .clk_i     (clk_i),
      .ld_i      (ld_s),
      .coord_a_i (coord_q[0]),
      .coord_b_i (coord_q[1]),
      .coord_c_i (coord_q[2]),
      .coef_i    (coef),
      .result_o  (res[g])
    );
  end

  assign s_axis_tready_o = rdy[0];
  assign m_axis_tvalid_o = vld_q[NS-1];
  assign m_axis_tuser_o  = st_q[NS-1];
  assign m_axis_tdata_o  = lag1d_pkg::OUT_DATA_W'({cnt_q[NS-1], res[3], res[2],
                                                   res[1], res[0]});

endmodule

// ===== src/lag1d_slot.sv =====
// ----------------------------------------------------------------------------
// Lagrange 1D basis slot
// Horner evaluation of one cubic over four register stages, then rounding
// to nearest and saturation into the output register.
// ----------------------------------------------------------------------------
module lag1d_slot (
  input  logic                                   clk_i,
  input  lag1d_pkg::stage_ld_t                   ld_i,
  input  logic [lag1d_pkg::COORD_W-1:0]          coord_a_i,
  input  logic [lag1d_pkg::COORD_W-1:0]          coord_b_i,
  input  logic [lag1d_pkg::COORD_W-1:0]          coord_c_i,
  input  lag1d_pkg::coef_quad_t                  coef_i,
  output logic signed [lag1d_pkg::OUT_W-1:0]     result_o
);

  localparam int CW = lag1d_pkg::COORD_W + 1;
  localparam int F  = lag1d_pkg::FRAC_BITS;

  localparam logic signed [lag1d_pkg::Q_W-1:0] OUT_MAX =
    lag1d_pkg::Q_W'((64'sd1 <<< (lag1d_pkg::OUT_W - 1)) - 64'sd1);
  localparam logic signed [lag1d_pkg::Q_W-1:0] OUT_MIN = -OUT_MAX - lag1d_pkg::Q_W'(1);

  lag1d_pkg::coef_quad_t coef_a_q;
  lag1d_pkg::coef_t      b1_b_q, b0_b_q, b0_c_q;

  logic signed [lag1d_pkg::H1_W-1:0] h1_d, h1_b_q;
  logic signed [lag1d_pkg::H2_W-1:0] h2_d, h2_c_q;
  logic signed [lag1d_pkg::H3_W-1:0] h3_d, h3_d_q, rnd;
  logic signed [lag1d_pkg::Q_W-1:0]  q;
  logic signed [lag1d_pkg::OUT_W-1:0] res_d, res_q;
  logic signed [CW-1:0] ca, cb, cc;

  assign ca = $signed({1'b0, coord_a_i});
  assign cb = $signed({1'b0, coord_b_i});
  assign cc = $signed({1'b0, coord_c_i});

  always_comb begin
    h1_d = lag1d_pkg::H1_W'(coef_a_q[3]) * lag1d_pkg::H1_W'(ca)
         + (lag1d_pkg::H1_W'(coef_a_q[2]) <<< F);
    h2_d = lag1d_pkg::H2_W'(h1_b_q) * lag1d_pkg::H2_W'(cb)
         + (lag1d_pkg::H2_W'(b1_b_q) <<< (2 * F));
    h3_d = lag1d_pkg::H3_W'(h2_c_q) * lag1d_pkg::H3_W'(cc)
         + (lag1d_pkg::H3_W'(b0_c_q) <<< (3 * F));
    rnd  = h3_d_q + (lag1d_pkg::H3_W'(1) <<< (2 * F));
    q    = $signed(rnd[lag1d_pkg::H3_W-1:2*F+1]);
    if (q > OUT_MAX) begin
      res_d = lag1d_pkg::OUT_W'(OUT_MAX);
    end else if (q < OUT_MIN) begin
      res_d = lag1d_pkg::OUT_W'(OUT_MIN);
    end else begin
      res_d = q[lag1d_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.a) begin
      coef_a_q <= coef_i;
    end
    if (ld_i.b) begin
      h1_b_q <= h1_d;
      b1_b_q <= coef_a_q[1];
      b0_b_q <= coef_a_q[0];
    end
    if (ld_i.c) begin
      h2_c_q <= h2_d;
      b0_c_q <= b0_b_q;
    end
    if (ld_i.d) begin
      h3_d_q <= h3_d;
    end
    if (ld_i.e) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

endmodule

// ===== src/lag1d_checker.sv =====
// ----------------------------------------------------------------------------
// Lagrange 1D basis checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module lag1d_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [lag1d_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  input logic [0:0]                        m_axis_tuser_o
);

  localparam int W  = lag1d_pkg::OUT_W;
  localparam int CB = lag1d_pkg::NUM_SLOTS * W;

  logic [lag1d_pkg::CNT_W-1:0] cnt;
  assign cnt = m_axis_tdata_o[CB+lag1d_pkg::CNT_W-1:CB];

  // An unsupported order must come out as an all-zero result with no count.
  a_bad_order_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0] == lag1d_pkg::STATUS_BAD_ORDER)
    |-> (cnt == '0 && m_axis_tdata_o[CB-1:0] == '0))
    else $error("bad order result not cleared");

  a_ok_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0] == lag1d_pkg::STATUS_OK)
    |-> (cnt == lag1d_pkg::CNT_W'(2) || cnt == lag1d_pkg::CNT_W'(3)
         || cnt == lag1d_pkg::CNT_W'(4)))
    else $error("count out of range for a good order");

  // With a count of two, slots 2 and 3 are zero.
  a_unused_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && cnt == lag1d_pkg::CNT_W'(2))
    |-> (m_axis_tdata_o[CB-1:2*W] == '0))
    else $error("unused slots not zero");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i)
    |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("stalled result changed");

endmodule

bind lagrange_1d_basis_eval lag1d_checker u_lag1d_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
